@@ rtl/core/pld_pkg.sv @@
package pld_pkg;

    localparam int CMD_W = 2;
    localparam int POS_W = 7;
    localparam int VAL_W = 17;

    localparam int DEPTH_DEFAULT = 64;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRINT  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_INS_SHIFT = 5'b00010,
        S_INS_LAST  = 5'b00100,
        S_DEL_SHIFT = 5'b01000,
        S_PRINT     = 5'b10000
    } state_t;

endpackage

@@ rtl/core/positional_list_insert_delete.sv @@
// Positional list: an ordered list of up to DEPTH 17-bit values.
// Requests arrive on req_valid/req_stall with command, position and value.
// A request is taken at a rising edge with req_valid high and req_stall low.
// Insert places value at a 1-based position and moves later entries back;
// delete removes the entry at a 1-based position and closes the gap; print
// streams every held value on res_valid/res_stall as element, with last set
// on the final one. An empty print, an unused command and any out-of-range
// or full-list request cause no change and no result.
// An insert at the tail writes with no move; else the later entries move
// back by one from the tail down, then the value is written. A delete at
// the tail only shortens the list; else the later entries move forward by
// one. Each move step is one read and one write of the single-port-pair
// list memory. A print gives one element per cycle while res_stall is low.
// When the receiver stalls, the print holds its place and the element waits
// in the output register; new requests are stalled until the print or a move ends.
// Reset clears the length to zero and the state to idle; the memory is not
// cleared, since only written entries are ever read.
module positional_list_insert_delete #(
    parameter int DEPTH = pld_pkg::DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [pld_pkg::CMD_W-1:0] command,
    input  logic [pld_pkg::POS_W-1:0] position,
    input  logic [pld_pkg::VAL_W-1:0] value,
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic [pld_pkg::VAL_W-1:0] element,
    output logic                      last
);

    import pld_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int PW = POS_W + 1;

    state_t             state_reg, state_next;
    logic [LW-1:0]      length_reg, length_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   out_elem_reg, out_elem_next;
    logic               out_last_reg, out_last_next;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [VAL_W-1:0]   wdata;
    logic               re;
    logic [AW-1:0]      raddr;
    logic [VAL_W-1:0]   rdata;

    logic               accept;
    logic [PW-1:0]      pos_ext;
    logic [PW-1:0]      len_ext;
    logic               ins_ok;
    logic               del_ok;
    logic               out_free;
    logic               is_last;

    pld_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_list_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign pos_ext   = PW'(position);
    assign len_ext   = PW'(length_reg);
    assign ins_ok    = (pos_ext != '0) && (pos_ext <= len_ext + PW'(1))
                       && (len_ext < PW'(DEPTH));
    assign del_ok    = (pos_ext != '0) && (pos_ext <= len_ext);
    assign out_free  = !out_valid_reg || !res_stall;
    assign is_last   = (LW'(idx_reg) + LW'(1)) == length_reg;

    assign res_valid = out_valid_reg;
    assign element   = out_elem_reg;
    assign last      = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        length_next    = length_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_elem_next  = out_elem_reg;
        out_last_next  = out_last_reg;
        we             = 1'b0;
        waddr          = idx_reg;
        wdata          = rdata;
        re             = 1'b0;
        raddr          = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                slot_next = AW'(position - 1'b1);
                                val_next  = value;
                                if (pos_ext == len_ext + PW'(1))
                                begin
                                    // Append at the tail: no entries move.
                                    we          = 1'b1;
                                    waddr       = AW'(position - 1'b1);
                                    wdata       = value;
                                    length_next = length_reg + 1'b1;
                                end
                                else
                                begin
                                    idx_next   = AW'(length_reg);
                                    re         = 1'b1;
                                    raddr      = AW'(length_reg - 1'b1);
                                    state_next = S_INS_SHIFT;
                                end
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (del_ok)
                            begin
                                if (pos_ext == len_ext)
                                begin
                                    length_next = length_reg - 1'b1;
                                end
                                else
                                begin
                                    idx_next   = AW'(position - 1'b1);
                                    re         = 1'b1;
                                    raddr      = AW'(position);
                                    state_next = S_DEL_SHIFT;
                                end
                            end
                        end
                        CMD_PRINT:
                        begin
                            if (length_reg != '0)
                            begin
                                idx_next   = '0;
                                re         = 1'b1;
                                raddr      = '0;
                                state_next = S_PRINT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_INS_SHIFT:
            begin
                // The entry read last cycle moves back by one.
                we    = 1'b1;
                waddr = idx_reg;
                wdata = rdata;
                if (idx_reg == slot_reg + AW'(1))
                begin
                    state_next = S_INS_LAST;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                    re       = 1'b1;
                    raddr    = idx_reg - AW'(2);
                end
            end

            S_INS_LAST:
            begin
                we          = 1'b1;
                waddr       = slot_reg;
                wdata       = val_reg;
                length_next = length_reg + 1'b1;
                state_next  = S_IDLE;
            end

            S_DEL_SHIFT:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                wdata = rdata;
                if (LW'(idx_reg) + LW'(1) == length_reg - 1'b1)
                begin
                    length_next = length_reg - 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    re       = 1'b1;
                    raddr    = idx_reg + AW'(2);
                end
            end

            S_PRINT:
            begin
                // Read data holds while the output register is full and stalled.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_elem_next  = rdata;
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        re       = 1'b1;
                        raddr    = idx_reg + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        slot_reg     <= slot_next;
        val_reg      <= val_next;
        out_elem_reg <= out_elem_next;
        out_last_reg <= out_last_next;
    end

endmodule

@@ rtl/core/pld_ram.sv @@
module pld_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/pld_checker.sv @@
module pld_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_stall,
    input logic                      res_valid,
    input logic                      res_stall,
    input logic [pld_pkg::VAL_W-1:0] element,
    input logic                      last
);

    // A stalled result keeps its contents.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(element) && $stable(last))
        else $error("stalled result changed");

    // A new result is only produced while a print holds off requests.
    a_res_from_print: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_stall))
        else $error("result appeared outside a print");

    // No request is taken in the cycle just before a fresh result appears.
    a_no_accept_before_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(req_valid && !req_stall))
        else $error("request accepted while a print was loading");

    // A print that has more elements to go keeps the block busy.
    a_print_continues: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !last |=> res_valid || req_stall)
        else $error("print ended without a last element");

endmodule

bind positional_list_insert_delete pld_checker u_pld_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .element   (element),
    .last      (last)
);

@@ verif/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pld_pkg::*;

    localparam int                LIST_DEPTH  = DEPTH_DEFAULT;
    localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
    localparam int                STALL_LIMIT = 4000;
    localparam int                REPORT_MAX  = 10;

    typedef struct packed {
        logic [VAL_W-1:0] element;
        logic             last;
    } print_beat_t;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic             res_valid;
    logic             res_stall;
    logic [VAL_W-1:0] element;
    logic             last;

    // Expected contents of the list, head first, and the print beats still owed.
    logic [VAL_W-1:0] held_values[$];
    print_beat_t      pending_beats[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned fail_count;
    int unsigned quiet_cycles;

    positional_list_insert_delete #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .command  (command),
        .position (position),
        .value    (value),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .element  (element),
        .last     (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void report_failure(input string msg);
        if (fail_count < REPORT_MAX)
        begin
            $display("%0t: %s", $realtime, msg);
        end
        fail_count++;
    endfunction

    // Updates the expected list for one accepted request and queues any print beats.
    function automatic void apply_request(input logic [CMD_W-1:0] cmd,
                                          input logic [POS_W-1:0] pos,
                                          input logic [VAL_W-1:0] val);
        int          len;
        print_beat_t beat;
        len = held_values.size();
        if (cmd == CMD_INSERT)
        begin
            if (pos >= 1 && pos <= len + 1 && len < LIST_DEPTH)
            begin
                held_values.insert(pos - 1, val);
            end
        end
        else if (cmd == CMD_DELETE)
        begin
            if (pos >= 1 && pos <= len)
            begin
                held_values.delete(pos - 1);
            end
        end
        else if (cmd == CMD_PRINT)
        begin
            for (int i = 0; i < len; i++)
            begin
                beat.element = held_values[i];
                beat.last    = (i == len - 1);
                pending_beats.push_back(beat);
            end
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        command   = cmd;
        position  = pos;
        value     = val;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        apply_request(cmd, pos, val);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid = 1'b0;
        while (pending_beats.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Mostly well-formed inserts and deletes that keep the list short, plus prints,
    // out-of-range requests and raw noise.
    task automatic send_random_request();
        int               roll;
        int               len;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        roll = $urandom_range(99);
        len  = held_values.size();
        val  = VAL_W'($urandom);
        if (roll < 8)
        begin
            cmd = CMD_W'($urandom_range(3));
            pos = POS_W'($urandom_range(127));
        end
        else if (roll < 18)
        begin
            cmd = CMD_PRINT;
            pos = POS_W'($urandom_range(127));
        end
        else if (roll < 28)
        begin
            if ($urandom_range(1))
            begin
                cmd = CMD_INSERT;
                if (len == LIST_DEPTH)
                    pos = POS_W'($urandom_range(127));
                else
                    pos = $urandom_range(1) ? '0 : POS_W'($urandom_range(127, len + 2));
            end
            else
            begin
                cmd = CMD_DELETE;
                pos = $urandom_range(1) ? '0 : POS_W'($urandom_range(127, len + 1));
            end
        end
        else if (len == 0 || (len < 32 && $urandom_range(31) >= len))
        begin
            cmd = CMD_INSERT;
            pos = POS_W'($urandom_range(len + 1, 1));
        end
        else
        begin
            cmd = CMD_DELETE;
            pos = POS_W'($urandom_range(len, 1));
        end
        send_request(cmd, pos, val);
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(CMD_PRINT,  7'd0,   17'd0);
        send_request(CMD_DELETE, 7'd1,   17'd0);
        send_request(CMD_DELETE, 7'd0,   17'd0);
        send_request(CMD_INSERT, 7'd0,   17'd5);
        send_request(CMD_INSERT, 7'd2,   17'd6);
        send_request(CMD_INSERT, 7'd1,   17'd0);
        send_request(CMD_INSERT, 7'd2,   17'h1FFFF);
        send_request(CMD_INSERT, 7'd1,   17'd100000);
        send_request(CMD_INSERT, 7'd2,   17'h0AAAA);
        send_request(CMD_PRINT,  7'd0,   17'd0);
        send_request(CMD_INSERT, 7'd6,   17'd7);
        send_request(CMD_DELETE, 7'd5,   17'd0);
        send_request(CMD_UNUSED, 7'd1,   17'h1FFFF);
        send_request(CMD_DELETE, 7'd4,   17'd0);
        send_request(CMD_DELETE, 7'd1,   17'd0);
        send_request(CMD_INSERT, 7'd3,   17'h15555);
        send_request(CMD_DELETE, 7'd2,   17'd0);
        send_request(CMD_PRINT,  7'd127, 17'h1FFFF);
        send_request(CMD_INSERT, 7'd127, 17'd9);
        send_request(CMD_DELETE, 7'd127, 17'd0);
        send_request(CMD_DELETE, 7'd1,   17'd0);
        send_request(CMD_DELETE, 7'd1,   17'd0);
        send_request(CMD_PRINT,  7'd0,   17'd0);
    endtask

    // Fills the list to capacity, tries inserts into the full list, prints it
    // whole and then empties it again.
    task automatic test_full_list();
        logic [VAL_W-1:0] val;
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        while (held_values.size() < LIST_DEPTH)
        begin
            val = VAL_W'($urandom);
            if (held_values.size() == LIST_DEPTH - 1)
                send_request(CMD_INSERT, 7'd64, val);
            else
                send_request(CMD_INSERT,
                             POS_W'($urandom_range(held_values.size() + 1, 1)), val);
        end
        send_request(CMD_INSERT, 7'd65, 17'd1);
        send_request(CMD_INSERT, 7'd1,  17'd2);
        send_request(CMD_PRINT,  7'd0,  17'd0);
        // Hold off until the whole print has come out.
        wait_drained();
        @(negedge clk);
        send_request(CMD_DELETE, 7'd65, 17'd0);
        send_request(CMD_DELETE, 7'd64, 17'd0);
        while (held_values.size() > 0)
        begin
            send_request(CMD_DELETE, POS_W'($urandom_range(held_values.size(), 1)), 17'd0);
            if (held_values.size() == LIST_DEPTH / 2)
                send_request(CMD_PRINT, 7'd0, 17'd0);
        end
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int          count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            send_random_request();
        end
    endtask

    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        print_beat_t beat;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                report_failure($sformatf("unexpected element %0h last %0b", element, last));
            end
            else
            begin
                beat = pending_beats.pop_front();
                if (element !== beat.element)
                    report_failure($sformatf("element: expected %0h, got %0h",
                                             beat.element, element));
                if (last !== beat.last)
                    report_failure($sformatf("last: expected %0b, got %0b", beat.last, last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        command        = CMD_INSERT;
        position       = '0;
        value          = '0;
        res_stall      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fail_count     = 0;
        quiet_cycles   = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_full_list();
        test_random_traffic(0,  0,  78);
        test_random_traffic(73, 0,  78);
        test_random_traffic(0,  73, 78);
        test_random_traffic(27, 27, 78);

        wait_drained();
        // Let any shift still in progress finish and catch stray results.
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pld_pkg.sv
rtl/core/pld_ram.sv
rtl/core/positional_list_insert_delete.sv
rtl/core/pld_checker.sv
verif/testbench.sv
